// File: sv/shdn_pkg.sv
package shdn_pkg;

  localparam int unsigned MAX_RING_DEF = 1023;
  localparam int unsigned RING_IN_W = 11;
  localparam int unsigned STEP_IN_W = 16;
  localparam int unsigned RING_W = 10;
  localparam int unsigned STEP_W = 13;
  localparam int unsigned DIST_W = 11;
  localparam int unsigned NB_RING_W = 11;
  localparam int unsigned SIDE_W = 3;

  // Signed width wide enough for doubled coordinates and intermediate sums.
  localparam int unsigned XY_W = 16;
  // Step after the ring adjustment: 16-bit step plus up to 3 * ring.
  localparam int unsigned WSTEP_W = 18;

  localparam logic [SIDE_W-1:0] SIDE_N  = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_NE = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_SE = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_S  = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_SW = 3'd4;
  localparam logic [SIDE_W-1:0] SIDE_NW = 3'd5;

  // Unsigned divider stage record: remainder being built, quotient bits.
  typedef struct packed {
    logic [WSTEP_W-1:0] rem;
    logic [WSTEP_W-1:0] quo;
  } div_t;

endpackage

// File: sv/shdn_norm.sv
// Normalizes one hex: ring fold and saturation, then a pipelined restoring
// division of the step by 6*ring (one quotient bit per stage), then a second
// pipelined division of the principal step by ring to get sector and offset.
module shdn_norm #(
  parameter int unsigned MAX_RING = shdn_pkg::MAX_RING_DEF
) (
  input  logic                                 clk,
  input  logic signed [shdn_pkg::RING_IN_W-1:0] ring_i,
  input  logic signed [shdn_pkg::STEP_IN_W-1:0] step_i,
  input  logic                                 en_i,
  output logic [shdn_pkg::RING_W-1:0]          ring_o,
  output logic [shdn_pkg::STEP_W-1:0]          step_o,
  output logic [2:0]                           sector_o,
  output logic [shdn_pkg::RING_W-1:0]          ofs_o
);
  localparam int unsigned WS = shdn_pkg::WSTEP_W;
  localparam int unsigned RW = shdn_pkg::RING_W;
  localparam int unsigned SW = shdn_pkg::STEP_W;
  // Number of stages for the mod-6r division, one bit each.
  localparam int unsigned NQ = WS;
  // Quotient step/ring is at most 5: three bits.
  localparam int unsigned NS = 3;

  // Stage 0: fold sign and saturate.
  logic [RW-1:0]        ring0_r;
  logic                 neg0_r;
  logic [WS-1:0]        mag0_r;
  logic [RW:0]          rmag;
  logic [RW-1:0]        rsat;
  logic signed [WS:0]   st;
  logic signed [WS:0]   st_abs;

  always_comb begin
    rmag = ring_i[shdn_pkg::RING_IN_W-1] ? (RW+1)'(-ring_i) : (RW+1)'(ring_i);
    rsat = (rmag > (RW+1)'(MAX_RING)) ? RW'(MAX_RING) : rmag[RW-1:0];
    st = (WS+1)'(step_i);
    if (ring_i[shdn_pkg::RING_IN_W-1]) begin
      st = st + (WS+1)'(3 * {8'd0, rsat});
    end
    st_abs = st[WS] ? -st : st;
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      ring0_r <= rsat;
      neg0_r  <= st[WS];
      mag0_r  <= st_abs[WS-1:0];
    end
  end

  // Modulo pipeline: restoring division of |step| by 6*ring.
  logic [RW-1:0] ringq_r [NQ+1];
  logic          negq_r  [NQ+1];
  logic [WS-1:0] remq_r  [NQ+1];
  logic [WS-1:0] dvdq_r  [NQ+1];

  always_comb begin
    ringq_r[0] = ring0_r;
    negq_r[0]  = neg0_r;
    remq_r[0]  = '0;
    dvdq_r[0]  = mag0_r;
  end

  for (genvar i = 0; i < NQ; i++) begin : g_mod
    logic [WS:0]   sh;
    logic [WS:0]   dv;
    logic [WS-1:0] rn;
    always_comb begin
      dv = (WS+1)'(6 * {8'd0, ringq_r[i]});
      sh = {remq_r[i], dvdq_r[i][WS-1-i]};
      rn = (sh >= dv) ? WS'(sh - dv) : sh[WS-1:0];
    end
    always_ff @(posedge clk) begin
      if (en_i) begin
        ringq_r[i+1] <= ringq_r[i];
        negq_r[i+1]  <= negq_r[i];
        remq_r[i+1]  <= rn;
        dvdq_r[i+1]  <= dvdq_r[i];
      end
    end
  end

  // Fix the sign of the remainder.
  logic [RW-1:0] ringm_r;
  logic [SW-1:0] stepm_r;
  logic [WS-1:0] six;
  always_comb six = WS'(6 * {8'd0, ringq_r[NQ]});
  always_ff @(posedge clk) begin
    if (en_i) begin
      ringm_r <= ringq_r[NQ];
      if (ringq_r[NQ] == '0) begin
        stepm_r <= '0;
      end else if (negq_r[NQ] && remq_r[NQ] != '0) begin
        stepm_r <= SW'(six - remq_r[NQ]);
      end else begin
        stepm_r <= SW'(remq_r[NQ]);
      end
    end
  end

  // Sector pipeline: three quotient bits of step / ring.
  logic [RW-1:0] rings_r [NS+1];
  logic [SW-1:0] steps_r [NS+1];
  logic [SW-1:0] rems_r  [NS+1];
  logic [2:0]    quos_r  [NS+1];

  always_comb begin
    rings_r[0] = ringm_r;
    steps_r[0] = stepm_r;
    rems_r[0]  = stepm_r;
    quos_r[0]  = '0;
  end

  for (genvar j = 0; j < NS; j++) begin : g_sec
    logic [SW+2:0] dv;
    logic          ge;
    always_comb begin
      dv = (SW+3)'({3'd0, rings_r[j]}) << (NS-1-j);
      ge = (rings_r[j] != '0) && ((SW+3)'(rems_r[j]) >= dv);
    end
    always_ff @(posedge clk) begin
      if (en_i) begin
        rings_r[j+1] <= rings_r[j];
        steps_r[j+1] <= steps_r[j];
        rems_r[j+1]  <= ge ? SW'((SW+3)'(rems_r[j]) - dv) : rems_r[j];
        quos_r[j+1]  <= {quos_r[j][1:0], ge};
      end
    end
  end

  assign ring_o   = rings_r[NS];
  assign step_o   = steps_r[NS];
  assign sector_o = quos_r[NS];
  assign ofs_o    = rems_r[NS][RW-1:0];
endmodule

// File: sv/shdn_geom.sv
// Maps both hexes to doubled x/y, then computes distance, adjacency and the
// neighbor of A converted back to ring/step over four registered stages.
module shdn_geom (
  input  logic                           clk,
  input  logic                           en_i,
  input  logic [shdn_pkg::RING_W-1:0]    ar_i,
  input  logic [2:0]                     asec_i,
  input  logic [shdn_pkg::RING_W-1:0]    aofs_i,
  input  logic [shdn_pkg::RING_W-1:0]    br_i,
  input  logic [2:0]                     bsec_i,
  input  logic [shdn_pkg::RING_W-1:0]    bofs_i,
  input  logic [shdn_pkg::SIDE_W-1:0]    side_i,
  output logic [shdn_pkg::DIST_W-1:0]    dist_o,
  output logic                           adj_o,
  output logic [shdn_pkg::NB_RING_W-1:0] nbr_o,
  output logic [shdn_pkg::STEP_W-1:0]    nbs_o
);
  localparam int unsigned XW = shdn_pkg::XY_W;
  typedef logic signed [XW-1:0] xy_t;

  function automatic logic [2*XW-1:0] to_xy(input logic [shdn_pkg::RING_W-1:0] r,
                                            input logic [2:0] sec,
                                            input logic [shdn_pkg::RING_W-1:0] o);
    xy_t x;
    xy_t y;
    xy_t rr;
    xy_t oo;
    rr = xy_t'({1'b0, r});
    oo = xy_t'({1'b0, o});
    case (sec)
      3'd0: begin x = oo <<< 1; y = (rr <<< 1) - oo; end
      3'd1: begin x = rr <<< 1; y = rr - (oo <<< 1); end
      3'd2: begin x = (rr - oo) <<< 1; y = -(rr + oo); end
      3'd3: begin x = -(oo <<< 1); y = oo - (rr <<< 1); end
      3'd4: begin x = -(rr <<< 1); y = (oo <<< 1) - rr; end
      default: begin x = (oo - rr) <<< 1; y = rr + oo; end
    endcase
    if (r == '0) begin
      x = '0;
      y = '0;
    end
    return {x, y};
  endfunction

  // Stage 1: coordinates and neighbor offset.
  xy_t ax_r, ay_r, bx_r, by_r, nx_r, ny_r;
  logic nvld_r;
  always_ff @(posedge clk) begin
    if (en_i) begin
      {ax_r, ay_r} <= to_xy(ar_i, asec_i, aofs_i);
      {bx_r, by_r} <= to_xy(br_i, bsec_i, bofs_i);
      nvld_r <= 1'b1;
      case (side_i)
        shdn_pkg::SIDE_N:  begin nx_r <= '0;         ny_r <= xy_t'(2);  end
        shdn_pkg::SIDE_NE: begin nx_r <= xy_t'(2);   ny_r <= xy_t'(1);  end
        shdn_pkg::SIDE_SE: begin nx_r <= xy_t'(2);   ny_r <= xy_t'(-1); end
        shdn_pkg::SIDE_S:  begin nx_r <= '0;         ny_r <= xy_t'(-2); end
        shdn_pkg::SIDE_SW: begin nx_r <= xy_t'(-2);  ny_r <= xy_t'(-1); end
        shdn_pkg::SIDE_NW: begin nx_r <= xy_t'(-2);  ny_r <= xy_t'(1);  end
        default: begin nx_r <= '0; ny_r <= '0; nvld_r <= 1'b0; end
      endcase
    end
  end

  // Stage 2: differences and neighbor position, snapped to a hex center.
  xy_t dx_r, dy_r, px_r, py_r;
  logic pv_r;
  xy_t ddx, ddy, qx, qy;
  always_comb begin
    ddx = ax_r - bx_r;
    ddy = ay_r - by_r;
    qx = ax_r + nx_r;
    qy = ay_r + ny_r;
    qx = qx - xy_t'({15'd0, qx[0]});
    if (qx[1]) begin
      if (!qy[0]) qy = qy - xy_t'(1);
    end else begin
      qy = qy - xy_t'({15'd0, qy[0]});
    end
  end
  always_ff @(posedge clk) begin
    if (en_i) begin
      dx_r <= ddx[XW-1] ? -ddx : ddx;
      dy_r <= ddy[XW-1] ? -ddy : ddy;
      px_r <= qx;
      py_r <= qy;
      pv_r <= nvld_r;
    end
  end

  // Stage 3: distance and adjacency; neighbor direction.
  xy_t hx;
  logic [2:0] dir;
  xy_t dd;
  logic [2:0] dir_r;
  xy_t hx_r, x3_r, y3_r;
  logic pv3_r, zero3_r;
  logic [shdn_pkg::DIST_W-1:0] dist3_r;
  logic adj3_r;
  always_comb begin
    hx = (px_r[XW-1] ? -px_r : px_r) >>> 1;
    dir = 3'((py_r < hx) ? 1 : 0) + 3'((py_r < -hx) ? 1 : 0);
    if (px_r[XW-1]) dir = 3'd5 - dir;
    dd = dx_r >>> 1;
    if (dx_r < (dy_r <<< 1)) dd = dd + ((dy_r - dd) >>> 1);
  end
  always_ff @(posedge clk) begin
    if (en_i) begin
      dist3_r <= shdn_pkg::DIST_W'(dd);
      adj3_r  <= (dx_r == '0) ? (dy_r <= xy_t'(2)) :
                 ((dx_r == xy_t'(2)) && (dy_r == xy_t'(1)));
      dir_r   <= dir;
      hx_r    <= hx;
      x3_r    <= px_r;
      y3_r    <= py_r;
      pv3_r   <= pv_r;
      zero3_r <= (px_r == '0) && (py_r == '0);
    end
  end

  // Stage 4: ring and step of the neighbor. All divisions are exact.
  xy_t rg, of, sp;
  always_comb begin
    case (dir_r)
      3'd0: begin rg = (y3_r + hx_r) >>> 1; of = hx_r; end
      3'd1: begin rg = hx_r; of = (hx_r - y3_r) >>> 1; end
      3'd2: begin rg = (x3_r - (y3_r <<< 1)) >>> 2; of = rg - hx_r; end
      3'd3: begin rg = (hx_r - y3_r) >>> 1; of = hx_r; end
      3'd4: begin rg = hx_r; of = (hx_r + y3_r) >>> 1; end
      default: begin rg = ((y3_r <<< 1) - x3_r) >>> 2; of = rg - hx_r; end
    endcase
    sp = xy_t'({13'd0, dir_r}) * rg + of;
  end
  always_ff @(posedge clk) begin
    if (en_i) begin
      dist_o <= dist3_r;
      adj_o  <= adj3_r;
      if (!pv3_r || zero3_r) begin
        nbr_o <= '0;
        nbs_o <= '0;
      end else begin
        nbr_o <= shdn_pkg::NB_RING_W'(rg);
        nbs_o <= shdn_pkg::STEP_W'(sp);
      end
    end
  end
endmodule

// File: sv/spiral_hex_distance_neighbour.sv
// Hex geometry on ring/step spiral coordinates.
// A request is taken when start is high and busy is low; busy is always low
// because the pipeline never stalls, so one request enters every cycle.
// Each request gives exactly one result, shown on the out_ ports for a single
// cycle with out_valid high. The pipeline is made of the bit-serial stages:
// 18 for the modulo-6*ring reduction, three for the sector division by ring,
// plus fold, fixup and four geometry stages.
// Throughput is one request per cycle.
// The receiver cannot hold results off, so nothing backs up: each result is
// dropped from the ports after its cycle.
// A synchronous active-low reset clears the valid chain; data registers are
// not reset and any requests in flight are discarded.
module spiral_hex_distance_neighbour #(
  parameter int unsigned MAX_RING = shdn_pkg::MAX_RING_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [shdn_pkg::RING_IN_W-1:0] in_a_ring,
  input  logic signed [shdn_pkg::STEP_IN_W-1:0] in_a_step,
  input  logic signed [shdn_pkg::RING_IN_W-1:0] in_b_ring,
  input  logic signed [shdn_pkg::STEP_IN_W-1:0] in_b_step,
  input  logic [shdn_pkg::SIDE_W-1:0]           in_side,
  output logic                                  out_valid,
  output logic [shdn_pkg::RING_W-1:0]           out_norm_ring,
  output logic [shdn_pkg::STEP_W-1:0]           out_norm_step,
  output logic [shdn_pkg::DIST_W-1:0]           out_hex_distance,
  output logic                                  out_adjacent,
  output logic [shdn_pkg::NB_RING_W-1:0]        out_nb_ring,
  output logic [shdn_pkg::STEP_W-1:0]           out_nb_step
);
  localparam int unsigned NORM_LAT = shdn_pkg::WSTEP_W + 5;
  localparam int unsigned GEOM_LAT = 4;
  localparam int unsigned LAT = NORM_LAT + GEOM_LAT;
  localparam int unsigned RW = shdn_pkg::RING_W;
  localparam int unsigned SW = shdn_pkg::STEP_W;

  logic            en;
  logic [LAT-1:0]  vld_r;
  logic [LAT-1:0]  vld_nxt;

  assign busy = 1'b0;
  assign en   = 1'b1;
  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  logic [RW-1:0] ar, br, aofs, bofs;
  logic [SW-1:0] as, bs;
  logic [2:0]    asec, bsec;

  shdn_norm #(.MAX_RING(MAX_RING)) u_norm_a (
    .clk(clk), .ring_i(in_a_ring), .step_i(in_a_step), .en_i(en),
    .ring_o(ar), .step_o(as), .sector_o(asec), .ofs_o(aofs)
  );
  shdn_norm #(.MAX_RING(MAX_RING)) u_norm_b (
    .clk(clk), .ring_i(in_b_ring), .step_i(in_b_step), .en_i(en),
    .ring_o(br), .step_o(bs), .sector_o(bsec), .ofs_o(bofs)
  );

  // Side travels alongside the normalizer.
  logic [shdn_pkg::SIDE_W-1:0] side_r [NORM_LAT+1];
  assign side_r[0] = in_side;
  for (genvar i = 0; i < NORM_LAT; i++) begin : g_side
    always_ff @(posedge clk) side_r[i+1] <= side_r[i];
  end

  // Normalized A waits for the geometry stages.
  logic [RW-1:0] nr_r [GEOM_LAT];
  logic [SW-1:0] ns_r [GEOM_LAT];
  always_ff @(posedge clk) begin
    nr_r[0] <= ar;
    ns_r[0] <= as;
    for (int k = 1; k < GEOM_LAT; k++) begin
      nr_r[k] <= nr_r[k-1];
      ns_r[k] <= ns_r[k-1];
    end
  end

  shdn_geom u_geom (
    .clk(clk), .en_i(en),
    .ar_i(ar), .asec_i(asec), .aofs_i(aofs),
    .br_i(br), .bsec_i(bsec), .bofs_i(bofs),
    .side_i(side_r[NORM_LAT]),
    .dist_o(out_hex_distance), .adj_o(out_adjacent),
    .nbr_o(out_nb_ring), .nbs_o(out_nb_step)
  );

  assign out_valid     = vld_r[LAT-1];
  assign out_norm_ring = nr_r[GEOM_LAT-1];
  assign out_norm_step = ns_r[GEOM_LAT-1];

  // Every result reports a step inside its ring.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_norm_ring == '0 && out_norm_step == '0) ||
                   (out_norm_step < SW'(6 * out_norm_ring))))
    else $error("normalized step out of range");

  // A request that enters the valid chain comes out of it on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> ##(LAT-1) out_valid)
    else $error("result lost in pipeline");

  // Adjacency agrees with the distance.
  a_adj: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_adjacent == (out_hex_distance <= 1)))
    else $error("adjacency disagrees with distance");
endmodule
